// ===== rtl/core/hsl2rgba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsl2rgba_pkg;

    // Fixed point: fractions in units of 1/ONE, ONE == 1.0
    localparam int FRAC_BITS = 8;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int TURN      = 6 * ONE;

    // Field widths of the pixel transactions
    localparam int HUE_W  = 11;
    localparam int FRAC_W = FRAC_BITS + 1;
    localparam int CHAN_W = 8;

    // Datapath widths
    localparam int LEVEL_W  = 2 * FRAC_BITS + 1;   // p, up to ONE^2
    localparam int DIFF_W   = 2 * FRAC_BITS + 2;   // q - p, up to ONE^2
    localparam int WEIGHT_W = FRAC_BITS + 1;       // channel weight, 0..ONE
    localparam int MUL_W    = DIFF_W + WEIGHT_W;
    localparam int VAL_W    = 3 * FRAC_BITS + 1;   // channel value, up to ONE^3
    localparam int PROD_W   = 2 * FRAC_W;          // s * l

    typedef logic [HUE_W-1:0]    t_hue;
    typedef logic [FRAC_W-1:0]   t_frac;
    typedef logic [CHAN_W-1:0]   t_chan;
    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [DIFF_W-1:0]   t_diff;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [VAL_W-1:0]    t_val;
    typedef logic [PROD_W-1:0]   t_prod;

endpackage

`default_nettype wire

// ===== rtl/core/hsl2rgba_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hsl2rgba_in_if;
    logic                valid;
    logic                ready;
    hsl2rgba_pkg::t_hue  hue;
    hsl2rgba_pkg::t_frac saturation;
    hsl2rgba_pkg::t_frac lightness;
    hsl2rgba_pkg::t_frac alpha_in;

    modport source (output valid, output hue, output saturation, output lightness,
                    output alpha_in, input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    input alpha_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hsl2rgba_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hsl2rgba_out_if;
    logic                valid;
    logic                ready;
    hsl2rgba_pkg::t_chan red;
    hsl2rgba_pkg::t_chan green;
    hsl2rgba_pkg::t_chan blue;
    hsl2rgba_pkg::t_chan alpha_out;

    modport source (output valid, output red, output green, output blue,
                    output alpha_out, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hsl_to_rgba_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// HSL to 8-bit RGBA pixel converter. Takes one pixel transaction per clock
// unless stalled and returns one RGBA transaction for it, in order. Hue
// counts 1536 steps per turn (256 per sixth; 1536 and above wraps),
// saturation, lightness and alpha are fractions where 256 means 1.0 (values
// above 256 clamp to 256). The math is exact fixed point: the mixing levels
// q and p are built from l*s, each channel is 256*p plus (q-p) times a
// piecewise-linear weight of its hue position, and the result is scaled by
// 255/2^24 with truncation. Zero saturation needs no special path since
// q == p then. Throughput is one pixel per cycle while the sink keeps up;
// the pipe has five register stages (clamp and s*l multiply, level build,
// weight multiply, level add, 255 scaling). Backpressure stalls the whole
// pipe at once: i_pix.ready is low only while the output register holds a
// result the sink has not taken.

module hsl_to_rgba_converter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    hsl2rgba_in_if.sink        i_pix,
    hsl2rgba_out_if.source     o_pix
);

    localparam int NCH = 3;   // lanes: red, green, blue

    // ---------------------------------------------------------------
    // Small helpers
    // ---------------------------------------------------------------
    function automatic hsl2rgba_pkg::t_frac clamp_one(hsl2rgba_pkg::t_frac x);
        clamp_one = (x > hsl2rgba_pkg::FRAC_W'(hsl2rgba_pkg::ONE))
                  ? hsl2rgba_pkg::FRAC_W'(hsl2rgba_pkg::ONE) : x;
    endfunction

    // One conditional subtract: inputs are always below two turns
    function automatic hsl2rgba_pkg::t_hue wrap_turn(logic [hsl2rgba_pkg::HUE_W:0] x);
        logic [hsl2rgba_pkg::HUE_W:0] turn;
        turn = (hsl2rgba_pkg::HUE_W + 1)'(hsl2rgba_pkg::TURN);
        wrap_turn = (x >= turn) ? hsl2rgba_pkg::HUE_W'(x - turn)
                                : hsl2rgba_pkg::HUE_W'(x);
    endfunction

    // Trapezoid: ramp up over the first sixth, flat for two sixths,
    // ramp down over the fourth sixth, zero for the rest.
    function automatic hsl2rgba_pkg::t_weight chan_weight(hsl2rgba_pkg::t_hue t);
        hsl2rgba_pkg::t_hue four;
        four = hsl2rgba_pkg::HUE_W'(4 * hsl2rgba_pkg::ONE);
        if (t < hsl2rgba_pkg::HUE_W'(hsl2rgba_pkg::ONE)) begin
            chan_weight = hsl2rgba_pkg::WEIGHT_W'(t);
        end else if (t < hsl2rgba_pkg::HUE_W'(3 * hsl2rgba_pkg::ONE)) begin
            chan_weight = hsl2rgba_pkg::WEIGHT_W'(hsl2rgba_pkg::ONE);
        end else if (t < four) begin
            chan_weight = hsl2rgba_pkg::WEIGHT_W'(four - t);
        end else begin
            chan_weight = '0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Pipeline control: one global enable, valid bit per stage
    // ---------------------------------------------------------------
    logic       w_adv;
    logic [4:0] r_vld;

    assign w_adv       = !r_vld[4] || o_pix.ready;
    assign i_pix.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[3:0], i_pix.valid};
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: clamp, wrap, channel weights, s*l, alpha scaling
    // ---------------------------------------------------------------
    hsl2rgba_pkg::t_frac   w_sat, w_lit, w_alp;
    hsl2rgba_pkg::t_hue    w_hue;
    hsl2rgba_pkg::t_hue    w_pos [NCH];
    logic [hsl2rgba_pkg::FRAC_W+hsl2rgba_pkg::FRAC_BITS-1:0] w_alp_x255;

    hsl2rgba_pkg::t_weight n_s1_wgt [NCH];
    hsl2rgba_pkg::t_prod   n_s1_ls;
    hsl2rgba_pkg::t_chan   n_s1_alp;

    hsl2rgba_pkg::t_frac   r_s1_sat, r_s1_lit;
    hsl2rgba_pkg::t_prod   r_s1_ls;
    hsl2rgba_pkg::t_weight r_s1_wgt [NCH];
    hsl2rgba_pkg::t_chan   r_s1_alp;

    always_comb begin
        w_sat = clamp_one(i_pix.saturation);
        w_lit = clamp_one(i_pix.lightness);
        w_alp = clamp_one(i_pix.alpha_in);
        w_hue = wrap_turn({1'b0, i_pix.hue});

        // red leads green by a third of a turn, blue trails by a third
        w_pos[0] = wrap_turn({1'b0, w_hue}
                   + (hsl2rgba_pkg::HUE_W + 1)'(2 * hsl2rgba_pkg::ONE));
        w_pos[1] = w_hue;
        w_pos[2] = wrap_turn({1'b0, w_hue}
                   + (hsl2rgba_pkg::HUE_W + 1)'(4 * hsl2rgba_pkg::ONE));
        for (int c = 0; c < NCH; c++) begin
            n_s1_wgt[c] = chan_weight(w_pos[c]);
        end

        n_s1_ls = w_sat * w_lit;

        // a*255 = a*256 - a, then drop the fraction bits
        w_alp_x255 = {w_alp, hsl2rgba_pkg::FRAC_BITS'(0)}
                   - (hsl2rgba_pkg::FRAC_W + hsl2rgba_pkg::FRAC_BITS)'(w_alp);
        n_s1_alp = hsl2rgba_pkg::CHAN_W'(w_alp_x255 >> hsl2rgba_pkg::FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_sat <= w_sat;
            r_s1_lit <= w_lit;
            r_s1_ls  <= n_s1_ls;
            r_s1_wgt <= n_s1_wgt;
            r_s1_alp <= n_s1_alp;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: mixing levels p and d = q - p
    //   l < 1/2 : p = 256l - ls,        d = 2ls
    //   else    : p = 256l - 256s + ls, d = 2(256s - ls)
    // ---------------------------------------------------------------
    hsl2rgba_pkg::t_diff   w_l256, w_s256, w_ls;
    hsl2rgba_pkg::t_level  n_s2_p;
    hsl2rgba_pkg::t_diff   n_s2_d;

    hsl2rgba_pkg::t_level  r_s2_p;
    hsl2rgba_pkg::t_diff   r_s2_d;
    hsl2rgba_pkg::t_weight r_s2_wgt [NCH];
    hsl2rgba_pkg::t_chan   r_s2_alp;

    always_comb begin
        w_l256 = hsl2rgba_pkg::DIFF_W'({r_s1_lit, hsl2rgba_pkg::FRAC_BITS'(0)});
        w_s256 = hsl2rgba_pkg::DIFF_W'({r_s1_sat, hsl2rgba_pkg::FRAC_BITS'(0)});
        w_ls   = hsl2rgba_pkg::DIFF_W'(r_s1_ls);
        if (r_s1_lit < hsl2rgba_pkg::FRAC_W'(hsl2rgba_pkg::ONE / 2)) begin
            n_s2_p = hsl2rgba_pkg::LEVEL_W'(w_l256 - w_ls);
            n_s2_d = w_ls << 1;
        end else begin
            n_s2_p = hsl2rgba_pkg::LEVEL_W'(w_l256 - w_s256 + w_ls);
            n_s2_d = (w_s256 - w_ls) << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_p   <= n_s2_p;
            r_s2_d   <= n_s2_d;
            r_s2_wgt <= r_s1_wgt;
            r_s2_alp <= r_s1_alp;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: one (q-p)*weight multiplier per lane
    // ---------------------------------------------------------------
    logic [hsl2rgba_pkg::MUL_W-1:0] w_prod [NCH];
    hsl2rgba_pkg::t_val   n_s3_mix [NCH];

    hsl2rgba_pkg::t_val   r_s3_mix [NCH];
    hsl2rgba_pkg::t_level r_s3_p;
    hsl2rgba_pkg::t_chan  r_s3_alp;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_prod[c]   = r_s2_d * r_s2_wgt[c];
            // never exceeds ONE^3, so the top bits are zero
            n_s3_mix[c] = w_prod[c][hsl2rgba_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_mix <= n_s3_mix;
            r_s3_p   <= r_s2_p;
            r_s3_alp <= r_s2_alp;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: v = 256p + mix
    // ---------------------------------------------------------------
    hsl2rgba_pkg::t_val  n_s4_v [NCH];
    hsl2rgba_pkg::t_val  r_s4_v [NCH];
    hsl2rgba_pkg::t_chan r_s4_alp;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_s4_v[c] = hsl2rgba_pkg::VAL_W'({r_s3_p, hsl2rgba_pkg::FRAC_BITS'(0)})
                      + r_s3_mix[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_v   <= n_s4_v;
            r_s4_alp <= r_s3_alp;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5 (output register): floor(v*255 / ONE^3)
    // ---------------------------------------------------------------
    localparam int SCL_W = hsl2rgba_pkg::VAL_W + 8;
    logic [SCL_W-1:0]    w_scl [NCH];
    hsl2rgba_pkg::t_chan n_s5_c [NCH];
    hsl2rgba_pkg::t_chan r_s5_c [NCH];
    hsl2rgba_pkg::t_chan r_s5_alp;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_scl[c]  = {r_s4_v[c], 8'd0} - SCL_W'(r_s4_v[c]);
            n_s5_c[c] = w_scl[c][3*hsl2rgba_pkg::FRAC_BITS +: hsl2rgba_pkg::CHAN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_c   <= n_s5_c;
            r_s5_alp <= r_s4_alp;
        end
    end

    assign o_pix.valid     = r_vld[4];
    assign o_pix.red       = r_s5_c[0];
    assign o_pix.green     = r_s5_c[1];
    assign o_pix.blue      = r_s5_c[2];
    assign o_pix.alpha_out = r_s5_alp;

endmodule

`default_nettype wire

// ===== rtl/core/hsl2rgba_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsl2rgba_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire hsl2rgba_pkg::t_frac i_in_saturation,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire hsl2rgba_pkg::t_chan i_out_red,
    input wire hsl2rgba_pkg::t_chan i_out_green,
    input wire hsl2rgba_pkg::t_chan i_out_blue
);

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // whole pipe stalls only when the output register is blocked
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready disagrees with output backpressure");

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_out_red) && $stable(i_out_green) && $stable(i_out_blue))
        else $error("stalled result changed");

    // gray pixel comes out gray when the sink does not stall on the way
    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_saturation == '0)
            ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> i_out_valid && i_out_red == i_out_green && i_out_green == i_out_blue)
        else $error("zero saturation gave unequal channels");

endmodule

bind hsl_to_rgba_converter hsl2rgba_checker u_hsl2rgba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pix.valid),
    .i_in_ready      (i_pix.ready),
    .i_in_saturation (i_pix.saturation),
    .i_out_valid     (o_pix.valid),
    .i_out_ready     (o_pix.ready),
    .i_out_red       (o_pix.red),
    .i_out_green     (o_pix.green),
    .i_out_blue      (o_pix.blue)
);

`default_nettype wire

// ===== dv/hsl_to_rgba_converter_test.sv =====
`timescale 1ns / 1ps

module hsl_to_rgba_converter_test;
    import hsl2rgba_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    // Random pixels per idling phase; four phases give about 500 in total.
    localparam int PIXELS_PER_PHASE = 125;
    // Five pipe stages; wait longer than the pipe is deep before calling it quiet.
    localparam int SETTLE_CYCLES = 12;
    // Watchdog bound, far above what the slowest legal run needs.
    localparam int CYCLE_LIMIT = 200000;
    // Idling plan, in percent of cycles: none, sender only, receiver only, both.
    localparam int unsigned SEND_GAP_PCT [4] = '{0, 48, 0, 32};
    localparam int unsigned SINK_STALL_PCT [4] = '{0, 0, 48, 32};

    // One HSL pixel in and one RGBA pixel out, at the widths of the ports.
    typedef struct {
        t_hue  hue;
        t_frac saturation;
        t_frac lightness;
        t_frac alpha_in;
    } pixel_t;

    typedef struct {
        t_chan red;
        t_chan green;
        t_chan blue;
        t_chan alpha_out;
    } rgba_t;

    // Holds the RGBA values still owed by the block, oldest first, and the
    // count of mismatches seen so far.
    class rgba_scoreboard;
        rgba_t       owed_rgba[$];
        int unsigned mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // One channel of the piecewise-linear hue shape; lo and hi are the
        // p and q mixing levels in units of 1/ONE^2, pos is in 0..TURN-1.
        function t_chan shape_channel(longint unsigned lo, longint unsigned hi,
                                      longint unsigned pos);
            longint unsigned level;
            if (pos < ONE) begin
                level = ONE * lo + (hi - lo) * pos;
            end else if (pos < 3 * ONE) begin
                level = ONE * hi;
            end else if (pos < 4 * ONE) begin
                level = ONE * lo + (hi - lo) * (4 * ONE - pos);
            end else begin
                level = ONE * lo;
            end
            return t_chan'((level * 255) >> (3 * FRAC_BITS));
        endfunction

        function rgba_t hsl_to_rgba(pixel_t px);
            longint unsigned hue, sat, light, alpha, q_lvl, p_lvl;
            rgba_t           color;
            hue   = px.hue % TURN;
            sat   = (px.saturation > ONE) ? ONE : px.saturation;
            light = (px.lightness > ONE) ? ONE : px.lightness;
            alpha = (px.alpha_in > ONE) ? ONE : px.alpha_in;
            if (sat == 0) begin
                // gray: every channel is the lightness alone
                color.red   = t_chan'((light * 255) >> FRAC_BITS);
                color.green = color.red;
                color.blue  = color.red;
            end else begin
                if (2 * light < ONE) begin
                    q_lvl = light * (ONE + sat);
                end else begin
                    q_lvl = ONE * (light + sat) - light * sat;
                end
                p_lvl = 2 * ONE * light - q_lvl;
                color.red   = shape_channel(p_lvl, q_lvl, (hue + 2 * ONE) % TURN);
                color.green = shape_channel(p_lvl, q_lvl, hue);
                color.blue  = shape_channel(p_lvl, q_lvl, (hue + 4 * ONE) % TURN);
            end
            color.alpha_out = t_chan'((alpha * 255) >> FRAC_BITS);
            return color;
        endfunction

        function void note_pixel(pixel_t px);
            owed_rgba.push_back(hsl_to_rgba(px));
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("%0t ns: %s: got %0d, wanted %0d", $time, what, got, want);
            mismatch_count++;
        endtask

        task check_rgba(rgba_t got);
            rgba_t want;
            if (owed_rgba.size() == 0) begin
                report_mismatch("RGBA transaction with none owed", got.red, 0);
                return;
            end
            want = owed_rgba.pop_front();
            if (got.red != want.red)
                report_mismatch("red", got.red, want.red);
            if (got.green != want.green)
                report_mismatch("green", got.green, want.green);
            if (got.blue != want.blue)
                report_mismatch("blue", got.blue, want.blue);
            if (got.alpha_out != want.alpha_out)
                report_mismatch("alpha_out", got.alpha_out, want.alpha_out);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    hsl2rgba_in_if  pix_in ();
    hsl2rgba_out_if pix_out ();

    hsl_to_rgba_converter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    rgba_scoreboard sb = new();

    // Current idling odds; the stimulus process moves them phase by phase.
    int unsigned send_gap_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake must not hang the run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Fractions: mostly in 0..ONE, with the ends, zero and values that clamp.
    function automatic t_frac random_fraction();
        case ($urandom_range(9))
            0:       return t_frac'(0);
            1:       return t_frac'(ONE);
            2:       return t_frac'($urandom_range(2 ** FRAC_W - 1, ONE + 1));
            default: return t_frac'($urandom_range(ONE));
        endcase
    endfunction

    // Hue mostly within one turn; now and then past it, up to the full
    // 11-bit range, to exercise the wrap.
    function automatic pixel_t random_pixel();
        pixel_t px;
        if ($urandom_range(15) == 0)
            px.hue = t_hue'($urandom_range(2 ** HUE_W - 1));
        else
            px.hue = t_hue'($urandom_range(TURN - 1));
        px.saturation = random_fraction();
        px.lightness  = random_fraction();
        px.alpha_in   = random_fraction();
        return px;
    endfunction

    // Presents one HSL transaction after a random number of idle cycles and
    // holds it until the block takes it. Values are sampled right after the
    // edge, so they are the ones that the edge itself saw.
    task automatic send_pixel(input pixel_t px);
        while ($urandom_range(99) < send_gap_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.hue        <= px.hue;
        pix_in.saturation <= px.saturation;
        pix_in.lightness  <= px.lightness;
        pix_in.alpha_in   <= px.alpha_in;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        sb.note_pixel(px);
    endtask

    // Sender goes quiet until every owed RGBA transaction has come back and
    // the pipe has had time to empty.
    task automatic wait_for_drain();
        pix_in.valid <= 1'b0;
        while (sb.owed_rgba.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: takes RGBA transactions, checks them, and drops ready at
    // random by the odds of the current phase.
    initial begin
        pix_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pix_out.valid && pix_out.ready) begin
                sb.check_rgba('{pix_out.red, pix_out.green, pix_out.blue,
                                pix_out.alpha_out});
            end
            pix_out.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        pix_in.valid      <= 1'b0;
        pix_in.hue        <= '0;
        pix_in.saturation <= '0;
        pix_in.lightness  <= '0;
        pix_in.alpha_in   <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels, no idling on either side.
        // Gray: zero saturation at dark, light, clamped and odd lightness.
        send_pixel('{0, 0, 0, 0});
        send_pixel('{700, 0, 256, 256});
        send_pixel('{100, 0, 511, 511});
        send_pixel('{2047, 0, 129, 1});
        // Full saturation at mid lightness, hue on both sides of each corner
        // of the channel shape.
        send_pixel('{0, 256, 128, 256});
        send_pixel('{255, 256, 128, 128});
        send_pixel('{256, 256, 128, 255});
        send_pixel('{511, 256, 128, 256});
        send_pixel('{512, 256, 128, 256});
        send_pixel('{767, 256, 128, 256});
        send_pixel('{768, 256, 128, 256});
        send_pixel('{1023, 256, 128, 256});
        send_pixel('{1024, 256, 128, 256});
        send_pixel('{1279, 256, 128, 256});
        send_pixel('{1535, 256, 128, 256});
        // Hue past one turn wraps.
        send_pixel('{1536, 200, 90, 256});
        send_pixel('{2047, 200, 90, 256});
        // Lightness either side of one half, and fractions that clamp to one.
        send_pixel('{300, 256, 127, 256});
        send_pixel('{300, 1, 128, 256});
        send_pixel('{900, 511, 511, 257});
        send_pixel('{1200, 300, 64, 300});
        send_pixel('{1400, 256, 256, 511});
        wait_for_drain();

        // Random pixels through the idling plan, draining between phases.
        for (int phase = 0; phase < 4; phase++) begin
            send_gap_pct   = SEND_GAP_PCT[phase];
            sink_stall_pct = SINK_STALL_PCT[phase];
            repeat (PIXELS_PER_PHASE) send_pixel(random_pixel());
            wait_for_drain();
        end

        if (sb.mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
